// ===== hw/rtl/psi_pkg.sv =====
package psi_pkg;

    localparam int IN_DATA_W   = 64;
    localparam int OUT_DATA_W  = 208;
    localparam int CHAN_W      = 10;
    localparam int SUM_W       = 24;
    localparam int LIM_W       = 25;
    localparam int FRAMES_W    = 16;
    localparam int CHANS_W     = 11;
    localparam int CFG_DATA_W  = 16;
    localparam int FIFO_DEPTH  = 8;
    localparam int FIFO_PTR_W  = 3;
    localparam int FIFO_CNT_W  = 5;

    localparam logic [FRAMES_W-1:0] FRAMES_RESET = 16'd1;
    localparam logic [CHANS_W-1:0]  CHANS_RESET  = 11'd1024;

    localparam logic [SUM_W-1:0] AUTO_TOP   = 24'hFFFFFF;
    localparam logic [SUM_W-1:0] CROSS_TOP  = 24'h7FFFFF;
    localparam logic [SUM_W-1:0] CROSS_BOT  = 24'h800000;
    localparam logic [LIM_W-1:0] LIM_POS    = 25'h0FFFFFF;
    localparam logic [LIM_W-1:0] LIM_NEG    = 25'h1000000;

    typedef enum logic [0:0] {
        CFG_FRAMES = 1'b0,
        CFG_CHANS  = 1'b1
    } t_cfg_index;

    // one input request, byte 0 in the lowest bits
    typedef struct packed {
        logic signed [7:0] imag_odd;
        logic signed [7:0] real_odd;
        logic signed [7:0] imag_even;
        logic signed [7:0] real_even;
        logic [7:0]        qq_odd;
        logic [7:0]        qq_even;
        logic [7:0]        pp_odd;
        logic [7:0]        pp_even;
    } t_item;

    typedef struct packed {
        logic signed [SUM_W-1:0] im;
        logic signed [SUM_W-1:0] re;
        logic [SUM_W-1:0]        qq;
        logic [SUM_W-1:0]        pp;
    } t_chan_sums;

    // index 0 is the even channel of the pair
    typedef t_chan_sums [1:0] t_pair_sums;

    typedef struct packed {
        logic [5:0]              pad;
        logic signed [SUM_W-1:0] cross_max;
        logic signed [SUM_W-1:0] cross_min;
        logic [SUM_W-1:0]        auto_max;
        logic [SUM_W-1:0]        auto_min;
        logic signed [SUM_W-1:0] imag_total;
        logic signed [SUM_W-1:0] real_total;
        logic [SUM_W-1:0]        qq_total;
        logic [SUM_W-1:0]        pp_total;
        logic [CHAN_W-1:0]       channel;
    } t_result;

    typedef struct packed {
        logic             valid;
        logic             emit;
        logic             last_pair;
    } t_stage_ctl;

    function automatic logic [SUM_W-1:0] sat_add_auto(input logic [SUM_W-1:0] s,
                                                      input logic [7:0] v);
        logic [SUM_W:0] t;
        t = {1'b0, s} + {{(SUM_W-7){1'b0}}, v};
        return t[SUM_W] ? AUTO_TOP : t[SUM_W-1:0];
    endfunction

    function automatic logic [SUM_W-1:0] sat_add_cross(input logic [SUM_W-1:0] s,
                                                       input logic [7:0] v);
        logic [SUM_W:0] t;
        t = {s[SUM_W-1], s} + {{(SUM_W-7){v[7]}}, v};
        if (t[SUM_W] != t[SUM_W-1]) begin
            return t[SUM_W] ? CROSS_BOT : CROSS_TOP;
        end
        return t[SUM_W-1:0];
    endfunction

    function automatic logic [SUM_W-1:0] umin(input logic [SUM_W-1:0] a,
                                              input logic [SUM_W-1:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic [SUM_W-1:0] umax(input logic [SUM_W-1:0] a,
                                              input logic [SUM_W-1:0] b);
        return (a > b) ? a : b;
    endfunction

    function automatic logic [LIM_W-1:0] smin(input logic [LIM_W-1:0] a,
                                              input logic [LIM_W-1:0] b);
        return ($signed(a) < $signed(b)) ? a : b;
    endfunction

    function automatic logic [LIM_W-1:0] smax(input logic [LIM_W-1:0] a,
                                              input logic [LIM_W-1:0] b);
        return ($signed(a) > $signed(b)) ? a : b;
    endfunction

endpackage

// ===== hw/rtl/polarisation_spectrum_integrator.sv =====
// Full-Stokes spectral integrator.
// Slave stream: one request per channel pair, 8 bytes of PP, QQ and PQ data.
// Master stream: one result per channel, but only on the frame that closes
// an integration; tlast marks the final channel of the spectrum and that
// result also carries the auto and cross min/max of the whole spectrum.
// Config port: i_cfg_we writes frames_to_integrate (index 0) or
// channels_in_use (index 1); write only while the block is idle.
// A result passes the sum memory read (S1), the limit tracker (S2) and the
// result queue before it becomes visible on the master port.
// Throughput: one request per cycle while integrating, set by the single
// read-modify-write port of the pair-sum memory (writes forwarded to a read
// of the same pair in the next request). On an emitting frame each request
// makes two results, so the one-result-per-cycle master port holds
// emitting requests back once the queue fills.
// Reset: sums are cleared by a pass over every pair, one pair per cycle;
// s_axis_tready stays low until it ends. Config writes are taken.
// Stall: results wait in an 8-entry queue; integrating requests keep flowing
// while the master side stalls, emitting requests wait for queue space.
module polarisation_spectrum_integrator #(
    parameter int MAX_CHANNELS = 1024,
    parameter int COUNT_BITS   = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic                             i_cfg_index,
    input  logic [psi_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // pp_even, pp_odd, qq_even, qq_odd, real_even, imag_even, real_odd, imag_odd
    input  logic [psi_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // channel, pp_total, qq_total, real_total, imag_total, auto_min, auto_max,
    // cross_min, cross_max, zero pad
    output logic [psi_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    output logic                             m_axis_tlast
);

    localparam int PAIRS  = MAX_CHANNELS / 2;
    localparam int PAIR_W = (PAIRS > 1) ? $clog2(PAIRS) : 1;
    localparam int CH_W   = ($clog2(MAX_CHANNELS + 1) > psi_pkg::CHANS_W) ?
                            $clog2(MAX_CHANNELS + 1) : psi_pkg::CHANS_W;
    localparam int FC_W   = ((COUNT_BITS > psi_pkg::FRAMES_W) ?
                            COUNT_BITS : psi_pkg::FRAMES_W) + 1;
    localparam logic [CH_W-1:0]   CH_MAX    = CH_W'(MAX_CHANNELS);
    localparam logic [PAIR_W-1:0] PAIR_LAST = PAIR_W'(PAIRS - 1);

    // ---------------- configuration
    logic [psi_pkg::FRAMES_W-1:0] r_frames;
    logic [psi_pkg::CHANS_W-1:0]  r_chans;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frames <= psi_pkg::FRAMES_RESET;
            r_chans  <= psi_pkg::CHANS_RESET;
        end else if (i_cfg_we) begin
            case (psi_pkg::t_cfg_index'(i_cfg_index))
                psi_pkg::CFG_FRAMES: r_frames <= i_cfg_wdata[psi_pkg::FRAMES_W-1:0];
                psi_pkg::CFG_CHANS:  r_chans  <= i_cfg_wdata[psi_pkg::CHANS_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- request side: pair and frame counters
    logic                  r_clr_busy;
    logic [PAIR_W-1:0]     r_clr_addr;
    logic [PAIR_W-1:0]     r_pair;
    logic [COUNT_BITS-1:0] r_frame_cnt;
    logic [PAIR_W-1:0]     n_pair;
    logic [COUNT_BITS-1:0] n_frame_cnt;

    logic [CH_W-1:0]       ch_even;
    logic [CH_W-1:0]       ch_sat;
    logic [CH_W-1:0]       pairs_cur;
    logic [FC_W-1:0]       frames_eff;
    logic                  next_end;
    logic                  next_emit;
    logic                  accept;

    psi_pkg::t_stage_ctl   r_s1;
    psi_pkg::t_stage_ctl   r_s2;
    logic [PAIR_W-1:0]     r_s1_pair;
    logic [PAIR_W-1:0]     r_s2_pair;
    psi_pkg::t_item        r_s1_item;
    logic [psi_pkg::FIFO_CNT_W-1:0] r_fifo_cnt;
    logic [psi_pkg::FIFO_CNT_W-1:0] fifo_reserved;

    always_comb begin
        ch_even = CH_W'(r_chans) & ~CH_W'(1);
        if (ch_even < CH_W'(2)) begin
            ch_sat = CH_W'(2);
        end else if (ch_even > CH_MAX) begin
            ch_sat = CH_MAX;
        end else begin
            ch_sat = ch_even;
        end
        pairs_cur  = ch_sat >> 1;
        frames_eff = (r_frames == '0) ? FC_W'(1) : FC_W'(r_frames);
        next_end   = (CH_W'(r_pair) + CH_W'(1)) >= pairs_cur;
        next_emit  = (FC_W'(r_frame_cnt) + FC_W'(1)) >= frames_eff;

        // emitting requests need room for two results beyond those in flight
        fifo_reserved = r_fifo_cnt
                      + ((r_s1.valid && r_s1.emit) ? psi_pkg::FIFO_CNT_W'(2) : '0)
                      + (r_s2.valid ? psi_pkg::FIFO_CNT_W'(2) : '0);
        s_axis_tready = !r_clr_busy &&
                        (!next_emit ||
                         fifo_reserved <= psi_pkg::FIFO_CNT_W'(psi_pkg::FIFO_DEPTH - 2));
        accept = s_axis_tvalid && s_axis_tready;

        n_pair      = r_pair;
        n_frame_cnt = r_frame_cnt;
        if (accept) begin
            if (next_end) begin
                n_pair      = '0;
                n_frame_cnt = next_emit ? '0 : r_frame_cnt + COUNT_BITS'(1);
            end else begin
                n_pair = r_pair + PAIR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pair      <= '0;
            r_frame_cnt <= '0;
            r_clr_busy  <= 1'b1;
            r_clr_addr  <= '0;
        end else begin
            r_pair      <= n_pair;
            r_frame_cnt <= n_frame_cnt;
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + PAIR_W'(1);
                if (r_clr_addr == PAIR_LAST) begin
                    r_clr_busy <= 1'b0;
                end
            end
        end
    end

    // ---------------- pair-sum memory, read in S0, written back in S1
    psi_pkg::t_pair_sums r_mem [PAIRS];
    psi_pkg::t_pair_sums r_rdata;
    psi_pkg::t_pair_sums r_fwd_data;
    logic                r_fwd_hit;
    psi_pkg::t_pair_sums old_sums;
    psi_pkg::t_pair_sums new_sums;
    psi_pkg::t_pair_sums wr_data;
    psi_pkg::t_pair_sums out_sums;
    logic                wr_en;
    logic [PAIR_W-1:0]   wr_addr;
    logic [7:0]          pp_in [2];
    logic [7:0]          qq_in [2];
    logic [7:0]          re_in [2];
    logic [7:0]          im_in [2];

    always_comb begin
        pp_in[0] = r_s1_item.pp_even;
        pp_in[1] = r_s1_item.pp_odd;
        qq_in[0] = r_s1_item.qq_even;
        qq_in[1] = r_s1_item.qq_odd;
        re_in[0] = r_s1_item.real_even;
        re_in[1] = r_s1_item.real_odd;
        im_in[0] = r_s1_item.imag_even;
        im_in[1] = r_s1_item.imag_odd;

        old_sums = r_fwd_hit ? r_fwd_data : r_rdata;
        for (int k = 0; k < 2; k++) begin
            new_sums[k].pp = psi_pkg::sat_add_auto(old_sums[k].pp, pp_in[k]);
            new_sums[k].qq = psi_pkg::sat_add_auto(old_sums[k].qq, qq_in[k]);
            new_sums[k].re = psi_pkg::sat_add_cross(old_sums[k].re, re_in[k]);
            new_sums[k].im = psi_pkg::sat_add_cross(old_sums[k].im, im_in[k]);
        end

        out_sums = new_sums;
        if (r_s1_pair == '0) begin
            out_sums[0] = '0;
        end

        if (r_clr_busy) begin
            wr_en   = 1'b1;
            wr_addr = r_clr_addr;
            wr_data = '0;
        end else begin
            wr_en   = r_s1.valid;
            wr_addr = r_s1_pair;
            wr_data = r_s1.emit ? '0 : new_sums;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (accept) begin
            r_rdata <= r_mem[r_pair];
        end
    end

    // S1 payload and the forward path for a back-to-back hit on the same pair
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_pair  <= r_pair;
            r_s1_item  <= psi_pkg::t_item'(s_axis_tdata);
            r_fwd_data <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1      <= '0;
            r_fwd_hit <= 1'b0;
        end else begin
            r_s1.valid     <= accept;
            r_s1.emit      <= next_emit;
            r_s1.last_pair <= next_end;
            r_fwd_hit      <= accept && r_s1.valid && (r_s1_pair == r_pair);
        end
    end

    // ---------------- S2: spectrum limits and result queue push
    psi_pkg::t_pair_sums r_s2_sums;
    logic [psi_pkg::SUM_W-1:0] r_amin;
    logic [psi_pkg::SUM_W-1:0] r_amax;
    logic [psi_pkg::LIM_W-1:0] r_cmin;
    logic [psi_pkg::LIM_W-1:0] r_cmax;
    logic [psi_pkg::SUM_W-1:0] n_amin;
    logic [psi_pkg::SUM_W-1:0] n_amax;
    logic [psi_pkg::LIM_W-1:0] n_cmin;
    logic [psi_pkg::LIM_W-1:0] n_cmax;
    logic [psi_pkg::LIM_W-1:0] cx [4];
    psi_pkg::t_result    res_even;
    psi_pkg::t_result    res_odd;
    logic                odd_last;

    always_ff @(posedge i_clk) begin
        if (r_s1.valid && r_s1.emit) begin
            r_s2_pair <= r_s1_pair;
            r_s2_sums <= out_sums;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2 <= '0;
        end else begin
            r_s2.valid     <= r_s1.valid && r_s1.emit;
            r_s2.emit      <= r_s1.emit;
            r_s2.last_pair <= r_s1.last_pair;
        end
    end

    always_comb begin
        cx[0] = {r_s2_sums[0].re[psi_pkg::SUM_W-1], r_s2_sums[0].re};
        cx[1] = {r_s2_sums[0].im[psi_pkg::SUM_W-1], r_s2_sums[0].im};
        cx[2] = {r_s2_sums[1].re[psi_pkg::SUM_W-1], r_s2_sums[1].re};
        cx[3] = {r_s2_sums[1].im[psi_pkg::SUM_W-1], r_s2_sums[1].im};

        n_amin = psi_pkg::umin(r_amin,
                 psi_pkg::umin(psi_pkg::umin(r_s2_sums[0].pp, r_s2_sums[0].qq),
                               psi_pkg::umin(r_s2_sums[1].pp, r_s2_sums[1].qq)));
        n_amax = psi_pkg::umax(r_amax,
                 psi_pkg::umax(psi_pkg::umax(r_s2_sums[0].pp, r_s2_sums[0].qq),
                               psi_pkg::umax(r_s2_sums[1].pp, r_s2_sums[1].qq)));
        n_cmin = psi_pkg::smin(r_cmin,
                 psi_pkg::smin(psi_pkg::smin(cx[0], cx[1]), psi_pkg::smin(cx[2], cx[3])));
        n_cmax = psi_pkg::smax(r_cmax,
                 psi_pkg::smax(psi_pkg::smax(cx[0], cx[1]), psi_pkg::smax(cx[2], cx[3])));

        odd_last = r_s2.last_pair;

        res_even            = '0;
        res_even.channel    = psi_pkg::CHAN_W'({r_s2_pair, 1'b0});
        res_even.pp_total   = r_s2_sums[0].pp;
        res_even.qq_total   = r_s2_sums[0].qq;
        res_even.real_total = r_s2_sums[0].re;
        res_even.imag_total = r_s2_sums[0].im;

        res_odd             = '0;
        res_odd.channel     = psi_pkg::CHAN_W'({r_s2_pair, 1'b1});
        res_odd.pp_total    = r_s2_sums[1].pp;
        res_odd.qq_total    = r_s2_sums[1].qq;
        res_odd.real_total  = r_s2_sums[1].re;
        res_odd.imag_total  = r_s2_sums[1].im;
        if (odd_last) begin
            res_odd.auto_min  = n_amin;
            res_odd.auto_max  = n_amax;
            res_odd.cross_min = n_cmin[psi_pkg::SUM_W-1:0];
            res_odd.cross_max = n_cmax[psi_pkg::SUM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amin <= psi_pkg::AUTO_TOP;
            r_amax <= '0;
            r_cmin <= psi_pkg::LIM_POS;
            r_cmax <= psi_pkg::LIM_NEG;
        end else if (r_s2.valid) begin
            if (r_s2.last_pair) begin
                r_amin <= psi_pkg::AUTO_TOP;
                r_amax <= '0;
                r_cmin <= psi_pkg::LIM_POS;
                r_cmax <= psi_pkg::LIM_NEG;
            end else begin
                r_amin <= n_amin;
                r_amax <= n_amax;
                r_cmin <= n_cmin;
                r_cmax <= n_cmax;
            end
        end
    end

    // ---------------- result queue
    psi_pkg::t_result               r_q_data [psi_pkg::FIFO_DEPTH];
    logic [psi_pkg::FIFO_DEPTH-1:0] r_q_last;
    logic [psi_pkg::FIFO_PTR_W-1:0] r_wr_ptr;
    logic [psi_pkg::FIFO_PTR_W-1:0] r_rd_ptr;
    logic [psi_pkg::FIFO_PTR_W-1:0] wr_ptr_odd;
    logic [psi_pkg::FIFO_CNT_W-1:0] n_fifo_cnt;
    logic                           pop;

    always_comb begin
        wr_ptr_odd    = r_wr_ptr + psi_pkg::FIFO_PTR_W'(1);
        m_axis_tvalid = (r_fifo_cnt != '0);
        m_axis_tdata  = r_q_data[r_rd_ptr];
        m_axis_tlast  = r_q_last[r_rd_ptr];
        pop           = m_axis_tvalid && m_axis_tready;
        n_fifo_cnt    = r_fifo_cnt
                      + (r_s2.valid ? psi_pkg::FIFO_CNT_W'(2) : '0)
                      - (pop ? psi_pkg::FIFO_CNT_W'(1) : '0);
    end

    always_ff @(posedge i_clk) begin
        if (r_s2.valid) begin
            r_q_data[r_wr_ptr]   <= res_even;
            r_q_last[r_wr_ptr]   <= 1'b0;
            r_q_data[wr_ptr_odd] <= res_odd;
            r_q_last[wr_ptr_odd] <= odd_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr   <= '0;
            r_rd_ptr   <= '0;
            r_fifo_cnt <= '0;
        end else begin
            r_fifo_cnt <= n_fifo_cnt;
            if (r_s2.valid) begin
                r_wr_ptr <= r_wr_ptr + psi_pkg::FIFO_PTR_W'(2);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + psi_pkg::FIFO_PTR_W'(1);
            end
        end
    end

    // ---------------- checks
    a_fifo_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fifo_cnt <= psi_pkg::FIFO_CNT_W'(psi_pkg::FIFO_DEPTH))
        else $error("result queue overflow");

    a_no_req_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !s_axis_tready)
        else $error("request taken during clearing pass");

    a_no_wb_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !r_s1.valid)
        else $error("write-back collides with clearing pass");

    a_last_is_odd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> m_axis_tdata[0])
        else $error("spectrum end on an even channel");

    a_emit_flows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && next_emit) |=> ##1 r_s2.valid)
        else $error("emitting request lost before the limit stage");

endmodule
